@@ hw/rtl/atan2_pkg.sv @@
package atan2_pkg;

  localparam int CoordWidthDef = 16;
  localparam int AngleFracDef  = 13;
  localparam int AngleWidth    = 16;
  localparam int NumCoef       = 8;
  localparam int QuoBits       = 17;

  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [32:0] PiQ30     = 33'd3373259426;

  // horner coefficients in q1.30, highest power first
  function automatic logic signed [31:0] coef(input int idx);
    logic signed [31:0] c;
    begin
      case (idx)
        0:       c = 32'sh002af67e;
        1:       c = -32'sh00f7ee76;
        2:       c = 32'sh02a1bd96;
        3:       c = -32'sh04b6f60d;
        4:       c = 32'sh06c46edc;
        5:       c = -32'sh09143aee;
        6:       c = 32'sh0ccb3a01;
        default: c = -32'sh155546cf;
      endcase
      return c;
    end
  endfunction

  // per-item context carried beside the datapath
  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } quad_t;

endpackage

@@ hw/rtl/atan2_polynomial_core.sv @@
// four-quadrant arctangent, one beat in and one beat out per clock while out_ready is high
//
// in channel: in_y_coord / in_x_coord signed, taken when in_valid and
// in_ready are high. out channel: out_angle in signed radians with
// ANGLE_FRAC_BITS fraction bits, handed over on out_valid && out_ready.
//
// datapath is a row of cells: magnitude/ordering stage, QuoBits division
// cells (one quotient bit each), a2 and a3 stages, seven two-stage horner
// cells, then product, linear-term/clamp, reflection and rounding stages.
// throughput is one beat per clock while out_ready stays high.
//
// the whole row advances as one: when the output register holds a beat
// that is not taken, every stage holds and in_ready drops. reset clears
// the valid bits of all stages; payload registers are not reset.
module atan2_polynomial_core #(
  parameter int COORD_WIDTH     = atan2_pkg::CoordWidthDef,
  parameter int ANGLE_FRAC_BITS = atan2_pkg::AngleFracDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]     in_x_coord,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [atan2_pkg::AngleWidth-1:0] out_angle
);
  localparam int W    = COORD_WIDTH;
  localparam int QB   = atan2_pkg::QuoBits;
  localparam int NH   = atan2_pkg::NumCoef - 1;
  localparam int TAIL = 4;
  localparam int LAT  = 1 + QB + 2 + 2 * NH + TAIL;
  localparam int SH   = 30 - ANGLE_FRAC_BITS;

  // global enable: the row moves unless the output is stalled
  logic en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end
  assign out_valid = vld_r[LAT-1];

  // stage 0: magnitudes, min/max, seed remainder with lo*2^16 + hi/2
  logic [W:0] my, mx, lo, hi;
  atan2_pkg::quad_t q0;
  assign my = in_y_coord[W-1] ? (W+1)'(-$signed({in_y_coord[W-1], in_y_coord}))
                              : (W+1)'({1'b0, in_y_coord});
  assign mx = in_x_coord[W-1] ? (W+1)'(-$signed({in_x_coord[W-1], in_x_coord}))
                              : (W+1)'({1'b0, in_x_coord});
  assign lo = (mx < my) ? mx : my;
  assign hi = (mx < my) ? my : mx;

  always_comb begin
    q0.zero = (mx == '0) && (my == '0);
    q0.swap = my > mx;
    q0.xneg = in_x_coord[W-1];
    q0.yneg = in_y_coord[W-1];
  end

  // division of n = lo*2^16 + hi/2 by hi; quotient < 2^17.
  // the first W+1 numerator bits start the remainder after ordering
  localparam int DW = W + 1;
  logic [DW+16:0]  num0;
  logic [DW:0]     rem_s_r;
  logic [DW-1:0]   den_s_r;
  logic [QB-1:0]   quo_s_r;
  logic [QB-1:0]   nlow_r;
  atan2_pkg::quad_t quad_s_r;

  assign num0 = {lo, 16'd0} + (DW+17)'(hi >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s_r  <= {1'b0, num0[DW+16:17]};
      den_s_r  <= q0.zero ? (DW)'(1) : hi;
      quo_s_r  <= '0;
      nlow_r   <= num0[16:0];
      quad_s_r <= q0;
    end
  end

  // remaining numerator bits travel along so each cell shifts one in
  logic [DW:0]      rem_c  [QB+1];
  logic [DW-1:0]    den_c  [QB+1];
  logic [QB-1:0]    quo_c  [QB+1];
  logic [QB-1:0]    nl_c   [QB+1];
  atan2_pkg::quad_t quad_c [QB+1];

  assign rem_c[0]  = rem_s_r;
  assign den_c[0]  = den_s_r;
  assign quo_c[0]  = quo_s_r;
  assign nl_c[0]   = nlow_r;
  assign quad_c[0] = quad_s_r;

  for (genvar k = 0; k < QB; k++) begin : g_div
    // lo <= hi keeps the partial remainder below hi
    atan2_div_cell #(.W(DW)) u_cell (
      .clk(clk), .en(en), .rem_i(rem_c[k]),
      .den_i(den_c[k]), .quo_i(quo_c[k]), .nl_i(nl_c[k]), .quad_i(quad_c[k]),
      .rem_o(rem_c[k+1]), .den_o(den_c[k+1]), .quo_o(quo_c[k+1]),
      .nl_o(nl_c[k+1]), .quad_o(quad_c[k+1])
    );
  end

  // a2 and a3 stages
  logic [16:0] a_r;
  logic [30:0] a2_r;
  logic [16:0] a_d_r;
  logic [31:0] a3_r;
  logic [30:0] a2_d_r;
  logic [16:0] a_dd_r;
  atan2_pkg::quad_t qa_r, qb_r;
  logic [33:0] sq;
  logic [47:0] cu;

  assign sq = 34'(quo_c[QB]) * 34'(quo_c[QB]);
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= 31'((sq + 34'd2) >> 2);
      a_d_r <= quo_c[QB];
      qa_r  <= quad_c[QB];
    end
  end
  assign cu = 48'(a2_r) * 48'(a_d_r);
  always_ff @(posedge clk) begin
    if (en) begin
      a3_r   <= 32'((cu + 48'd32768) >> 16);
      a2_d_r <= a2_r;
      a_dd_r <= a_d_r;
      qb_r   <= qa_r;
    end
  end
  assign a_r = a_dd_r;

  // horner chain
  logic signed [31:0] p_h  [NH+1];
  logic [30:0]        a2_h [NH+1];
  logic [16:0]        a_h  [NH+1];
  logic [31:0]        a3_h [NH+1];
  atan2_pkg::quad_t   q_h  [NH+1];

  assign p_h[0]  = atan2_pkg::coef(0);
  assign a2_h[0] = a2_d_r;
  assign a_h[0]  = a_r;
  assign a3_h[0] = a3_r;
  assign q_h[0]  = qb_r;

  for (genvar k = 0; k < NH; k++) begin : g_horner
    atan2_horner_cell #(.IDX(k + 1)) u_cell (
      .clk(clk), .en(en), .p_i(p_h[k]), .a2_i(a2_h[k]), .a_i(a_h[k]),
      .a3_i(a3_h[k]), .quad_i(q_h[k]), .p_o(p_h[k+1]), .a2_o(a2_h[k+1]),
      .a_o(a_h[k+1]), .a3_o(a3_h[k+1]), .quad_o(q_h[k+1])
    );
  end

  // tail stage 1: p * a3 product
  logic [31:0]  pm;
  logic [63:0]  t1_prod_r;
  logic         t1_neg_r;
  logic [16:0]  t1_a_r;
  atan2_pkg::quad_t t1_q_r;
  assign pm = p_h[NH][31] ? 32'(-p_h[NH]) : 32'(p_h[NH]);
  always_ff @(posedge clk) begin
    if (en) begin
      t1_prod_r <= 64'(pm) * 64'(a3_h[NH]);
      t1_neg_r  <= p_h[NH][31];
      t1_a_r    <= a_h[NH];
      t1_q_r    <= q_h[NH];
    end
  end

  // tail stage 2: add linear term and clamp to 0..pi/2
  logic [33:0] t2_rnd;
  logic signed [35:0] t2_sum;
  logic [31:0] t2_r_r;
  atan2_pkg::quad_t t2_q_r;
  assign t2_rnd = 34'((t1_prod_r + 64'd536870912) >> 30);
  assign t2_sum = $signed({5'd0, t1_a_r, 14'd0})
                + (t1_neg_r ? -$signed({2'b00, t2_rnd}) : $signed({2'b00, t2_rnd}));
  always_ff @(posedge clk) begin
    if (en) begin
      if (t2_sum < 0) begin
        t2_r_r <= '0;
      end else if (t2_sum > $signed({4'd0, atan2_pkg::HalfPiQ30})) begin
        t2_r_r <= atan2_pkg::HalfPiQ30;
      end else begin
        t2_r_r <= t2_sum[31:0];
      end
      t2_q_r <= t1_q_r;
    end
  end

  // tail stage 3: octant and quadrant reflection
  logic [32:0] t3_r_r;
  logic [31:0] t3_oct;
  atan2_pkg::quad_t t3_q_r;
  assign t3_oct = t2_q_r.swap ? (atan2_pkg::HalfPiQ30 - t2_r_r) : t2_r_r;
  always_ff @(posedge clk) begin
    if (en) begin
      t3_r_r <= t2_q_r.xneg ? (atan2_pkg::PiQ30 - {1'b0, t3_oct}) : {1'b0, t3_oct};
      t3_q_r <= t2_q_r;
    end
  end

  // tail stage 4: round, sign, saturate; a zero input gives angle 0
  logic [33:0] t4_mag;
  logic signed [35:0] t4_ang;
  logic signed [atan2_pkg::AngleWidth-1:0] ang_r;
  assign t4_mag = (34'(t3_r_r) + (34'd1 << (SH - 1))) >> SH;
  assign t4_ang = t3_q_r.yneg ? -$signed({2'b00, t4_mag}) : $signed({2'b00, t4_mag});
  always_ff @(posedge clk) begin
    if (en) begin
      if (t3_q_r.zero) begin
        ang_r <= '0;
      end else if (t4_ang > 36'sd32767) begin
        ang_r <= 16'sh7fff;
      end else if (t4_ang < -36'sd32768) begin
        ang_r <= 16'sh8000;
      end else begin
        ang_r <= t4_ang[atan2_pkg::AngleWidth-1:0];
      end
    end
  end
  assign out_angle = ang_r;

  // a stalled output beat holds, the row holds while stalled, in_ready follows the output drain
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle))
    else $error("stalled output beat changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output drain");
endmodule

@@ hw/rtl/atan2_div_cell.sv @@
// one restoring-division step per cell, one quotient bit per cycle while en is high
module atan2_div_cell #(
  parameter int W = 17
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [W:0]                  rem_i,
  input  logic [W-1:0]                den_i,
  input  logic [atan2_pkg::QuoBits-1:0] quo_i,
  input  logic [atan2_pkg::QuoBits-1:0] nl_i,
  input  atan2_pkg::quad_t            quad_i,
  output logic [W:0]                  rem_o,
  output logic [W-1:0]                den_o,
  output logic [atan2_pkg::QuoBits-1:0] quo_o,
  output logic [atan2_pkg::QuoBits-1:0] nl_o,
  output atan2_pkg::quad_t            quad_o
);
  logic [W+1:0] sh;
  logic [W+1:0] diff;
  logic         ge;

  // next numerator bit shifts in below the partial remainder
  assign sh   = {rem_i, nl_i[atan2_pkg::QuoBits-1]};
  assign diff = sh - {2'b00, den_i};
  assign ge   = (sh >= {2'b00, den_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[W:0] : sh[W:0];
      den_o  <= den_i;
      quo_o  <= {quo_i[atan2_pkg::QuoBits-2:0], ge};
      nl_o   <= {nl_i[atan2_pkg::QuoBits-2:0], 1'b0};
      quad_o <= quad_i;
    end
  end
endmodule

@@ hw/rtl/atan2_horner_cell.sv @@
// one horner step: p <- round(p * a2 / 2^30) + c, two stages
module atan2_horner_cell #(
  parameter int IDX = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [31:0]       p_i,
  input  logic [30:0]              a2_i,
  input  logic [16:0]              a_i,
  input  logic [31:0]              a3_i,
  input  atan2_pkg::quad_t         quad_i,
  output logic signed [31:0]       p_o,
  output logic [30:0]              a2_o,
  output logic [16:0]              a_o,
  output logic [31:0]              a3_o,
  output atan2_pkg::quad_t         quad_o
);
  logic [31:0] mag;
  logic        neg_r;
  logic [62:0] prod_r;
  logic [30:0] a2_r;
  logic [16:0] a_r;
  logic [31:0] a3_r;
  atan2_pkg::quad_t quad_r;
  logic [32:0] rnd;
  logic signed [33:0] sum;

  assign mag = p_i[31] ? 32'(-p_i) : 32'(p_i);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 63'(mag) * 63'(a2_i);
      neg_r  <= p_i[31];
      a2_r   <= a2_i;
      a_r    <= a_i;
      a3_r   <= a3_i;
      quad_r <= quad_i;
    end
  end

  assign rnd = 33'((prod_r + 63'd536870912) >> 30);
  assign sum = (neg_r ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd}))
             + 34'(atan2_pkg::coef(IDX));

  always_ff @(posedge clk) begin
    if (en) begin
      p_o    <= sum[31:0];
      a2_o   <= a2_r;
      a_o    <= a_r;
      a3_o   <= a3_r;
      quad_o <= quad_r;
    end
  end
endmodule
